/* hdl/yrgb_pkg.sv */
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared types and register codes for the YUV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package yrgb_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_RED_ROW   = 3'd0,
    CFG_GREEN_ROW = 3'd1,
    CFG_BLUE_ROW  = 3'd2,
    CFG_LUMA_RNG  = 3'd3,
    CFG_CB_RNG    = 3'd4,
    CFG_CR_RNG    = 3'd5,
    CFG_MASK      = 3'd6
  } cfg_reg_t;

  // Load enables for the two register stages inside a pipeline section.
  typedef struct packed {
    logic en_a;
    logic en_b;
  } pipe_ctrl_t;

endpackage : yrgb_pkg

`default_nettype wire

/* hdl/yrgb_chan_map.sv */
// ----------------------------------------------------------------------------
// yrgb_chan_map
// Maps one normalized component onto its configured range in two stages:
// multiply by (max - min), then round, shift and add min; or pass the raw component.
// ----------------------------------------------------------------------------
`default_nettype none

module yrgb_chan_map #(
  parameter int FRAC_BITS = 12,
  parameter int COEF_BITS = 16,
  parameter int MAP_W     = 20
) (
  input  wire logic                        clk,
  input  wire yrgb_pkg::pipe_ctrl_t        ctrl,
  input  wire logic [FRAC_BITS:0]          x,
  input  wire logic                        map_en,
  input  wire logic [2*COEF_BITS-1:0]      range_reg,
  output      logic signed [MAP_W-1:0]     mapped
);
  import yrgb_pkg::*;

  localparam int PW = FRAC_BITS + COEF_BITS + 3;
  localparam int RW = PW - FRAC_BITS;
  localparam logic signed [PW-1:0] HALF_P = PW'(2 ** (FRAC_BITS - 1));

  logic signed [COEF_BITS-1:0] lo;
  logic signed [COEF_BITS-1:0] hi;
  logic signed [COEF_BITS:0]   diff;
  logic signed [PW-1:0]        prod;
  logic [FRAC_BITS:0]          x_q;
  logic signed [PW-1:0]        rnd_sum;
  logic signed [RW-1:0]        rnd_shift;
  logic signed [MAP_W-1:0]     mapped_next;

  // Range span; the user must change the configuration only while the block is idle (not enforced here).
  assign lo   = $signed(range_reg[COEF_BITS-1:0]);
  assign hi   = $signed(range_reg[2*COEF_BITS-1:COEF_BITS]);
  assign diff = (COEF_BITS+1)'(hi) - (COEF_BITS+1)'(lo);

  // Stage A: component times span.
  always_ff @(posedge clk) begin
    if (ctrl.en_a) begin
      prod <= PW'($signed({1'b0, x})) * PW'(diff);
      x_q  <= x;
    end
  end

  // Stage B: round to nearest (ties up), add the range minimum, or pass raw.
  always_comb begin
    rnd_sum   = prod + HALF_P;
    rnd_shift = $signed(rnd_sum[PW-1:FRAC_BITS]);
    if (map_en) begin
      mapped_next = MAP_W'(rnd_shift) + MAP_W'(lo);
    end else begin
      mapped_next = $signed(MAP_W'({1'b0, x_q}));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_b) begin
      mapped <= mapped_next;
    end
  end

endmodule : yrgb_chan_map

`default_nettype wire

/* hdl/yrgb_row_mac.sv */
// ----------------------------------------------------------------------------
// yrgb_row_mac
// One row of the color matrix: three products in one stage, then the sum,
// rounding and saturation to 0 .. 1.0 in the next.
// ----------------------------------------------------------------------------
`default_nettype none

module yrgb_row_mac #(
  parameter int FRAC_BITS = 12,
  parameter int COEF_BITS = 16,
  parameter int MAP_W     = 20
) (
  input  wire logic                     clk,
  input  wire yrgb_pkg::pipe_ctrl_t     ctrl,
  input  wire logic [3*COEF_BITS-1:0]   row_coefs,
  input  wire logic signed [MAP_W-1:0]  y_val,
  input  wire logic signed [MAP_W-1:0]  u_val,
  input  wire logic signed [MAP_W-1:0]  v_val,
  output      logic [FRAC_BITS:0]       color
);
  import yrgb_pkg::*;

  localparam int PW = COEF_BITS + MAP_W;
  localparam int AW = PW + 2;
  localparam int RW = AW - FRAC_BITS;
  localparam logic signed [AW-1:0] HALF_A = AW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [RW-1:0] ONE_R  = RW'(2 ** FRAC_BITS);
  localparam logic [FRAC_BITS:0]   ONE_O  = (FRAC_BITS+1)'(2 ** FRAC_BITS);

  logic signed [COEF_BITS-1:0] c_y;
  logic signed [COEF_BITS-1:0] c_u;
  logic signed [COEF_BITS-1:0] c_v;
  logic signed [PW-1:0]        p_y;
  logic signed [PW-1:0]        p_u;
  logic signed [PW-1:0]        p_v;
  logic signed [AW-1:0]        acc;
  logic signed [RW-1:0]        acc_rnd;
  logic [FRAC_BITS:0]          color_next;

  assign c_y = $signed(row_coefs[COEF_BITS-1:0]);
  assign c_u = $signed(row_coefs[2*COEF_BITS-1:COEF_BITS]);
  assign c_v = $signed(row_coefs[3*COEF_BITS-1:2*COEF_BITS]);

  // Stage A: the three coefficient products.
  always_ff @(posedge clk) begin
    if (ctrl.en_a) begin
      p_y <= PW'(c_y) * PW'(y_val);
      p_u <= PW'(c_u) * PW'(u_val);
      p_v <= PW'(c_v) * PW'(v_val);
    end
  end

  // Stage B: sum, round to nearest with ties up, saturate.
  always_comb begin
    acc     = AW'(p_y) + AW'(p_u) + AW'(p_v) + HALF_A;
    acc_rnd = $signed(acc[AW-1:FRAC_BITS]);
    if (acc_rnd < 0) begin
      color_next = '0;
    end else if (acc_rnd > ONE_R) begin
      color_next = ONE_O;
    end else begin
      color_next = acc_rnd[FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_b) begin
      color <= color_next;
    end
  end

endmodule : yrgb_row_mac

`default_nettype wire

/* hdl/yuv_to_rgb_matrix_convert.sv */
// ----------------------------------------------------------------------------
// yuv_to_rgb_matrix_convert
// Pixel converter from normalized YUV plus alpha to RGB plus alpha.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (luma_in, cb_in, cr_in, alpha_in) enter on in_valid while
//   in_stall is low. Output words (red_out, green_out, blue_out, alpha_out)
//   leave on out_valid while out_stall is low.
//   Registers are written on the cfg channel (cfg_valid, cfg_index,
//   cfg_data); cfg_ready is always high. Write them only while no word is
//   in flight.
//   The path from input word to output word is registered in two stages for the
//   range mapping (multiply, then round and offset) and two for the color
//   matrix (three multiplies per row, then sum, round and saturate).
//   Throughput is one word per cycle while the receiver does not stall.
//   Reset clears all stage valid bits and loads the default registers:
//   zero coefficients, ranges 0 .. 1.0 minus one LSB, all channels mapped.
//   When the receiver stalls, the output word holds; earlier stages keep
//   accepting words until every stage is full, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv_to_rgb_matrix_convert #(
  parameter int FRAC_BITS = 12,
  parameter int COEF_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Input channel
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic [FRAC_BITS:0]       luma_in,
  input  wire logic [FRAC_BITS:0]       cb_in,
  input  wire logic [FRAC_BITS:0]       cr_in,
  input  wire logic [FRAC_BITS:0]       alpha_in,
  // Output channel
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic [FRAC_BITS:0]       red_out,
  output      logic [FRAC_BITS:0]       green_out,
  output      logic [FRAC_BITS:0]       blue_out,
  output      logic [FRAC_BITS:0]       alpha_out,
  // Configuration channel
  input  wire logic                     cfg_valid,
  output      logic                     cfg_ready,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [3*COEF_BITS-1:0]   cfg_data
);
  import yrgb_pkg::*;

  localparam int MAP_W = (COEF_BITS + 4 > FRAC_BITS + 2) ? COEF_BITS + 4 : FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] ONE_V = (FRAC_BITS+1)'(2 ** FRAC_BITS);
  localparam logic [2*COEF_BITS-1:0] RANGE_RST =
    (2*COEF_BITS)'((2 ** FRAC_BITS) - 1) << COEF_BITS;

  // Configuration registers.
  logic [3*COEF_BITS-1:0] red_row;
  logic [3*COEF_BITS-1:0] green_row;
  logic [3*COEF_BITS-1:0] blue_row;
  logic [2*COEF_BITS-1:0] luma_rng;
  logic [2*COEF_BITS-1:0] cb_rng;
  logic [2*COEF_BITS-1:0] cr_rng;
  logic [2:0]             present_mask;

  // Pipeline control.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  pipe_ctrl_t map_ctrl;
  pipe_ctrl_t mac_ctrl;

  // Alpha rides alongside the color data.
  logic [FRAC_BITS:0] alpha1, alpha2, alpha3;
  logic [FRAC_BITS:0] alpha_clamp;

  logic signed [MAP_W-1:0] y_map;
  logic signed [MAP_W-1:0] u_map;
  logic signed [MAP_W-1:0] v_map;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      red_row      <= '0;
      green_row    <= '0;
      blue_row     <= '0;
      luma_rng     <= RANGE_RST;
      cb_rng       <= RANGE_RST;
      cr_rng       <= RANGE_RST;
      present_mask <= 3'b111;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_RED_ROW:   red_row      <= cfg_data;
        CFG_GREEN_ROW: green_row    <= cfg_data;
        CFG_BLUE_ROW:  blue_row     <= cfg_data;
        CFG_LUMA_RNG:  luma_rng     <= cfg_data[2*COEF_BITS-1:0];
        CFG_CB_RNG:    cb_rng       <= cfg_data[2*COEF_BITS-1:0];
        CFG_CR_RNG:    cr_rng       <= cfg_data[2*COEF_BITS-1:0];
        CFG_MASK:      present_mask <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // A stage loads when it is empty or its word moves on; bubbles fill in.
  assign rdy4 = !v4 || !out_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_stall  = !rdy1;
  assign out_valid = v4;

  assign map_ctrl = '{en_a: rdy1, en_b: rdy2};
  assign mac_ctrl = '{en_a: rdy3, en_b: rdy4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Alpha clamp and delay line.
  assign alpha_clamp = (alpha_in > ONE_V) ? ONE_V : alpha_in;

  always_ff @(posedge clk) begin
    if (rdy1) alpha1    <= alpha_clamp;
    if (rdy2) alpha2    <= alpha1;
    if (rdy3) alpha3    <= alpha2;
    if (rdy4) alpha_out <= alpha3;
  end

  // Range mapping per channel.
  yrgb_chan_map #(.FRAC_BITS(FRAC_BITS), .COEF_BITS(COEF_BITS), .MAP_W(MAP_W)) u_map_y (
    .clk(clk), .ctrl(map_ctrl), .x(luma_in), .map_en(present_mask[0]),
    .range_reg(luma_rng), .mapped(y_map)
  );

  yrgb_chan_map #(.FRAC_BITS(FRAC_BITS), .COEF_BITS(COEF_BITS), .MAP_W(MAP_W)) u_map_u (
    .clk(clk), .ctrl(map_ctrl), .x(cb_in), .map_en(present_mask[1]),
    .range_reg(cb_rng), .mapped(u_map)
  );

  yrgb_chan_map #(.FRAC_BITS(FRAC_BITS), .COEF_BITS(COEF_BITS), .MAP_W(MAP_W)) u_map_v (
    .clk(clk), .ctrl(map_ctrl), .x(cr_in), .map_en(present_mask[2]),
    .range_reg(cr_rng), .mapped(v_map)
  );

  // Color matrix rows.
  yrgb_row_mac #(.FRAC_BITS(FRAC_BITS), .COEF_BITS(COEF_BITS), .MAP_W(MAP_W)) u_row_r (
    .clk(clk), .ctrl(mac_ctrl), .row_coefs(red_row),
    .y_val(y_map), .u_val(u_map), .v_val(v_map), .color(red_out)
  );

  yrgb_row_mac #(.FRAC_BITS(FRAC_BITS), .COEF_BITS(COEF_BITS), .MAP_W(MAP_W)) u_row_g (
    .clk(clk), .ctrl(mac_ctrl), .row_coefs(green_row),
    .y_val(y_map), .u_val(u_map), .v_val(v_map), .color(green_out)
  );

  yrgb_row_mac #(.FRAC_BITS(FRAC_BITS), .COEF_BITS(COEF_BITS), .MAP_W(MAP_W)) u_row_b (
    .clk(clk), .ctrl(mac_ctrl), .row_coefs(blue_row),
    .y_val(y_map), .u_val(u_map), .v_val(v_map), .color(blue_out)
  );

  // An accepted word always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted word did not enter the first stage");

  // The input side only stalls when every stage holds a word that cannot move.
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && out_stall))
    else $error("input stalled while a stage could take a word");

  // Results are always saturated to the unit range.
  a_out_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red_out <= ONE_V && green_out <= ONE_V &&
                   blue_out <= ONE_V && alpha_out <= ONE_V))
    else $error("output word outside 0 .. 1.0");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule : yuv_to_rgb_matrix_convert

`default_nettype wire
